[rtl/lsc_pkg.sv]
// Shared types and constants for the letterbox bilinear scaler.
package lsc_pkg;

    localparam int SRC_XW    = 8;
    localparam int SRC_YW    = 8;
    localparam int MEM_AW    = SRC_XW + SRC_YW;
    localparam int PIX_W     = 24;
    localparam int DIM_W     = 9;
    localparam int TGT_W     = 11;
    localparam int OUT_CW    = 10;
    localparam int PAD_W     = 9;
    localparam int SCL_W     = 27;
    localparam int FRAC_BITS = 16;
    localparam int AXN_W     = 21;
    localparam int NUM_W     = AXN_W + FRAC_BITS;
    localparam int DEN_W     = 12;
    localparam int IP_W      = NUM_W - FRAC_BITS;
    localparam int WFR_W     = FRAC_BITS + 1;
    localparam int WGT_W     = 2 * WFR_W;
    localparam int PROD_W    = WGT_W + 8;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 11;
    localparam int QDEPTH    = 4;
    localparam int QAW       = 2;

    localparam logic [DIM_W-1:0] MAX_SRC_W  = 9'd256;
    localparam logic [DIM_W-1:0] MAX_SRC_H  = 9'd256;
    localparam logic [TGT_W-1:0] MAX_TARGET = 11'd1024;
    localparam logic [7:0]       PAD_GRAY   = 8'd114;
    localparam logic [WFR_W-1:0] FRAC_ONE   = WFR_W'(1) << FRAC_BITS;

    localparam logic [CFG_IW-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TARGET     = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SRC_XW-1:0] load_x;
        logic [SRC_YW-1:0] load_y;
        logic [PIX_W-1:0]  pix;
        logic [OUT_CW-1:0] out_x;
        logic [OUT_CW-1:0] out_y;
    } item_t;

    typedef struct packed {
        logic [7:0]       res_b;
        logic [7:0]       res_g;
        logic [7:0]       res_r;
        logic             in_content;
        logic [PAD_W-1:0] pad_left;
        logic [PAD_W-1:0] pad_top;
        logic [SCL_W-1:0] scale_fixed;
    } result_t;

endpackage

[rtl/letterbox_bilinear_scaler_core.sv]
// Top level of the letterbox bilinear scaler: input queue, execution side, output packing.
//
// Source pixels are loaded with tuser 0 (one transfer per cycle while the queue has
// room and no query is being worked on, into a 64K x 24 frame store addressed
// {load_y, load_x}); queries with tuser 1 return one letterbox output pixel each. A
// query inside the scaled image uses the single bit-serial divider (37 quotient bits)
// to map the x and then the y coordinate, then makes four reads of the single-port
// frame store and loads the output register; a query in the padding skips the
// divisions and the reads. The first query after any register write first runs three
// divisions for the scaled size and the scale factor. A four-entry queue in front lets
// transfers keep arriving while a query is worked on, and the output register holds a
// finished result until taken.
module letterbox_bilinear_scaler_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lsc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [lsc_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // load_x[7:0] load_y[15:8] pix_b[23:16] pix_g[31:24] pix_r[39:32]
    // out_x[49:40] out_y[59:50], zero above
    input  logic [63:0]                 s_tdata,
    // op[0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // res_b[7:0] res_g[15:8] res_r[23:16] pad_left[32:24] pad_top[41:33]
    // scale_fixed[68:42], zero above
    output logic [71:0]                 m_tdata,
    // in_content[0]
    output logic                        m_tuser
);
    import lsc_pkg::*;

    logic    q_valid;
    item_t   q_head;
    logic    q_pop;
    result_t res;

    lsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    lsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {3'b000, res.scale_fixed, res.pad_top, res.pad_left,
                      res.res_r, res.res_g, res.res_b};
    assign m_tuser = res.in_content;

endmodule

[rtl/lsc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module lsc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lsc_pkg::NUM_W-1:0]   num,
    input  logic [lsc_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [lsc_pkg::NUM_W-1:0]   quo
);
    import lsc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

[rtl/lsc_front.sv]
// Input side: takes stream transfers, sorts them into load or query items, queues them.
module lsc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [63:0]     s_tdata,
    input  logic            s_tuser,
    output logic            q_valid,
    output lsc_pkg::item_t  q_head,
    input  logic            q_pop
);
    import lsc_pkg::*;

    item_t          fifo_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    item_t          item;
    logic           push;
    logic           pop;

    always_comb begin
        item.op     = s_tuser;
        item.load_x = s_tdata[7:0];
        item.load_y = s_tdata[15:8];
        item.pix    = s_tdata[39:16];
        item.out_x  = s_tdata[49:40];
        item.out_y  = s_tdata[59:50];
    end

    assign s_tready = count_reg != (QAW+1)'(QDEPTH);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = count_reg != '0;
    assign q_head   = fifo_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

[rtl/lsc_back.sv]
// Execution side: frame store, letterbox geometry, coordinate mapping and bilinear blend.
module lsc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lsc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [lsc_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                         q_valid,
    input  lsc_pkg::item_t               q_head,
    output logic                         q_pop,
    output logic                         res_valid,
    input  logic                         res_ready,
    output lsc_pkg::result_t             res
);
    import lsc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DNW  = 4'd1;
    localparam logic [3:0] S_DNH  = 4'd2;
    localparam logic [3:0] S_DSCL = 4'd3;
    localparam logic [3:0] S_PREP = 4'd4;
    localparam logic [3:0] S_DX   = 4'd5;
    localparam logic [3:0] S_DY   = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;

    logic [DIM_W-1:0] cfg_w_reg;
    logic [DIM_W-1:0] cfg_h_reg;
    logic [TGT_W-1:0] cfg_t_reg;
    logic             geo_valid_reg;
    logic [TGT_W-1:0] nw_reg;
    logic [TGT_W-1:0] nh_reg;
    logic [SCL_W-1:0] scl_reg;

    logic [SRC_XW-1:0] x0_reg, x1_reg;
    logic [SRC_YW-1:0] y0_reg, y1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [2:0]       rd_cnt_reg;
    logic [WGT_W-1:0] wgt_reg;
    logic [ACC_W-1:0] acc_b_reg, acc_g_reg, acc_r_reg;
    logic             content_reg;

    logic [PIX_W-1:0] mem [2**MEM_AW];
    logic [PIX_W-1:0] rdata_reg;

    result_t          res_reg;
    logic             res_valid_reg;

    logic [DIM_W-1:0] w, h, m;
    logic [TGT_W-1:0] t;
    logic [TGT_W-1:0] diff_l, diff_t;
    logic [PAD_W-1:0] padl, padt;
    logic             content;
    logic [OUT_CW-1:0] dx, dy;
    logic [AXN_W-1:0] ax_num, ay_num;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [IP_W-1:0]  ip;
    logic             mem_wr, mem_rd;
    logic [MEM_AW-1:0] rd_addr;
    logic [WFR_W-1:0] wx, wy;
    logic [PROD_W-1:0] prod_b, prod_g, prod_r;
    logic             out_free;
    logic             out_load;

    function automatic logic [SRC_XW-1:0] axis_idx(input logic [IP_W-1:0] ipv,
                                                   input logic [DIM_W-1:0] s,
                                                   input logic upper);
        logic [IP_W-1:0] v;
        logic [IP_W-1:0] lim;
        v   = upper ? ipv : ((ipv == '0) ? '0 : ipv - 1'b1);
        lim = IP_W'(s) - 1'b1;
        if (v > lim) begin
            v = lim;
        end
        return v[SRC_XW-1:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic [ACC_W-1:0] a);
        logic [ACC_W-2*FRAC_BITS-1:0] v;
        v = a[ACC_W-1:2*FRAC_BITS];
        return (v > (ACC_W-2*FRAC_BITS)'(255)) ? 8'd255 : v[7:0];
    endfunction

    // Saturate the registers into their legal ranges, then derive the larger side and the paddings
    always_comb begin
        w = (cfg_w_reg == '0) ? DIM_W'(1) : ((cfg_w_reg > MAX_SRC_W) ? MAX_SRC_W : cfg_w_reg);
        h = (cfg_h_reg == '0) ? DIM_W'(1) : ((cfg_h_reg > MAX_SRC_H) ? MAX_SRC_H : cfg_h_reg);
        t = (cfg_t_reg == '0) ? TGT_W'(1) : ((cfg_t_reg > MAX_TARGET) ? MAX_TARGET : cfg_t_reg);
        m = (w > h) ? w : h;
        diff_l = t - nw_reg;
        diff_t = t - nh_reg;
        padl   = diff_l[PAD_W:1];
        padt   = diff_t[PAD_W:1];
    end

    always_comb begin
        content = (TGT_W'(q_head.out_x) < t) && (TGT_W'(q_head.out_y) < t)
               && (q_head.out_x >= OUT_CW'(padl))
               && ((TGT_W+1)'(q_head.out_x) < (TGT_W+1)'(padl) + (TGT_W+1)'(nw_reg))
               && (q_head.out_y >= OUT_CW'(padt))
               && ((TGT_W+1)'(q_head.out_y) < (TGT_W+1)'(padt) + (TGT_W+1)'(nh_reg));
        dx = q_head.out_x - OUT_CW'(padl);
        dy = q_head.out_y - OUT_CW'(padt);
        // (2d+1)*s + n, the source position shifted up by one pixel
        ax_num = AXN_W'(AXN_W'({dx, 1'b1}) * AXN_W'(w)) + AXN_W'(nw_reg);
        ay_num = AXN_W'(AXN_W'({dy, 1'b1}) * AXN_W'(h)) + AXN_W'(nh_reg);
    end

    always_comb begin
        div_num = '0;
        div_den = DEN_W'(m);
        unique case (state_reg)
            S_IDLE:  div_num = NUM_W'((DIM_W+TGT_W)'(w) * (DIM_W+TGT_W)'(t));
            S_DNW:   div_num = NUM_W'((DIM_W+TGT_W)'(h) * (DIM_W+TGT_W)'(t));
            S_DNH:   div_num = NUM_W'(t) << FRAC_BITS;
            S_PREP: begin
                div_num = {ax_num, {FRAC_BITS{1'b0}}};
                div_den = {nw_reg[DEN_W-2:0], 1'b0};
            end
            S_DX: begin
                div_num = {ay_num, {FRAC_BITS{1'b0}}};
                div_den = {nh_reg[DEN_W-2:0], 1'b0};
            end
            default: div_num = '0;
        endcase
    end

    assign ip       = div_quo[NUM_W-1:FRAC_BITS];
    assign out_free = !res_valid_reg || res_ready;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        q_pop      = 1'b0;
        mem_wr     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_head.op == OP_LOAD) begin
                        mem_wr = 1'b1;
                        q_pop  = 1'b1;
                    end else if (!geo_valid_reg) begin
                        div_start  = 1'b1;
                        state_next = S_DNW;
                    end else begin
                        state_next = S_PREP;
                    end
                end
            end
            S_DNW: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = S_DNH;
                end
            end
            S_DNH: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = S_DSCL;
                end
            end
            S_DSCL: begin
                if (div_done) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (content) begin
                    div_start  = 1'b1;
                    state_next = S_DX;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DX: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    state_next = S_DY;
                end
            end
            S_DY: begin
                if (div_done) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (rd_cnt_reg == 3'd4) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    q_pop      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Tap order: bit 0 picks the right column, bit 1 the lower row
    always_comb begin
        mem_rd  = (state_reg == S_RD) && !rd_cnt_reg[2];
        rd_addr = {rd_cnt_reg[1] ? y1_reg : y0_reg, rd_cnt_reg[0] ? x1_reg : x0_reg};
        wx      = rd_cnt_reg[0] ? WFR_W'(fx_reg) : FRAC_ONE - WFR_W'(fx_reg);
        wy      = rd_cnt_reg[1] ? WFR_W'(fy_reg) : FRAC_ONE - WFR_W'(fy_reg);
        prod_b  = PROD_W'(wgt_reg) * PROD_W'(rdata_reg[7:0]);
        prod_g  = PROD_W'(wgt_reg) * PROD_W'(rdata_reg[15:8]);
        prod_r  = PROD_W'(wgt_reg) * PROD_W'(rdata_reg[23:16]);
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[{q_head.load_y, q_head.load_x}] <= q_head.pix;
        end else if (mem_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_w_reg     <= 9'd256;
            cfg_h_reg     <= 9'd256;
            cfg_t_reg     <= 11'd640;
            geo_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                geo_valid_reg <= 1'b0;
                unique case (cfg_index)
                    CFG_SRC_WIDTH:  cfg_w_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_SRC_HEIGHT: cfg_h_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_TARGET:     cfg_t_reg <= cfg_wdata;
                    default:        ;
                endcase
            end else if (state_reg == S_DSCL && div_done) begin
                geo_valid_reg <= 1'b1;
            end
            if (out_load) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == S_DY && div_done) begin
                rd_cnt_reg <= '0;
            end else if (state_reg == S_RD) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DNW && div_done) begin
            nw_reg <= div_quo[TGT_W-1:0];
        end
        if (state_reg == S_DNH && div_done) begin
            nh_reg <= div_quo[TGT_W-1:0];
        end
        if (state_reg == S_DSCL && div_done) begin
            scl_reg <= div_quo[SCL_W-1:0];
        end
        if (state_reg == S_PREP) begin
            content_reg <= content;
        end
        if (state_reg == S_DX && div_done) begin
            x0_reg <= axis_idx(ip, w, 1'b0);
            x1_reg <= axis_idx(ip, w, 1'b1);
            fx_reg <= div_quo[FRAC_BITS-1:0];
        end
        if (state_reg == S_DY && div_done) begin
            y0_reg    <= axis_idx(ip, h, 1'b0);
            y1_reg    <= axis_idx(ip, h, 1'b1);
            fy_reg    <= div_quo[FRAC_BITS-1:0];
            acc_b_reg <= '0;
            acc_g_reg <= '0;
            acc_r_reg <= '0;
        end
        if (state_reg == S_RD) begin
            wgt_reg <= WGT_W'(wx) * WGT_W'(wy);
            // Accumulate the tap read in the previous cycle
            if (rd_cnt_reg != '0) begin
                acc_b_reg <= acc_b_reg + ACC_W'(prod_b);
                acc_g_reg <= acc_g_reg + ACC_W'(prod_g);
                acc_r_reg <= acc_r_reg + ACC_W'(prod_r);
            end
        end
        if (out_load) begin
            res_reg.res_b       <= content_reg ? to_byte(acc_b_reg) : PAD_GRAY;
            res_reg.res_g       <= content_reg ? to_byte(acc_g_reg) : PAD_GRAY;
            res_reg.res_r       <= content_reg ? to_byte(acc_r_reg) : PAD_GRAY;
            res_reg.in_content  <= content_reg;
            res_reg.pad_left    <= padl;
            res_reg.pad_top     <= padt;
            res_reg.scale_fixed <= scl_reg;
        end
    end

    lsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[bench/letterbox_bilinear_scaler_core_test.sv]
// Self-checking bench for the letterbox bilinear scaler core: loads, queries, register changes.
`timescale 1ns / 1ps

module letterbox_bilinear_scaler_core_test;
    import lsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [71:0]       m_tdata;
    logic              m_tuser;

    letterbox_bilinear_scaler_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // local copy of registers and frame store
    logic [23:0]       pixel_mem [0:65535];
    logic              pixel_known [0:65535];
    logic [DIM_W-1:0]  cur_width;
    logic [DIM_W-1:0]  cur_height;
    logic [TGT_W-1:0]  cur_target;

    result_t pending_pixels[$];
    int      mismatch_count;
    int      query_count;
    int      load_count;
    int      content_count;
    int      idle_cycles;
    logic    stall_mode;

    typedef struct {
        logic        op;
        logic [7:0]  lx, ly, pb, pg, pr;
        logic [9:0]  ox, oy;
        logic        fixed_res;   // expected result typed in
        logic [7:0]  fixed_gray;
        logic        fixed_content;
    } stim_row_t;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // position = (d+0.5)*s/n - 0.5, kept one pixel up so it stays positive
    function automatic void map_coord(input longint unsigned d, input longint unsigned s,
                                      input longint unsigned n, output longint unsigned i0,
                                      output longint unsigned i1, output longint unsigned fr);
        longint unsigned num, p, ip;
        num = (2 * d + 1) * s + n;
        p   = (num << FRAC_BITS) / (2 * n);
        ip  = p >> FRAC_BITS;
        fr  = p & ((64'd1 << FRAC_BITS) - 1);
        i0  = (ip == 0) ? 0 : ip - 1;
        i1  = ip;
        if (i0 > s - 1) i0 = s - 1;
        if (i1 > s - 1) i1 = s - 1;
    endfunction

    function automatic void letterbox_geometry(output longint unsigned w, h, t, nw, nh,
                                               padl, padt);
        longint unsigned m;
        w = clamp_dim(cur_width, 256);
        h = clamp_dim(cur_height, 256);
        t = clamp_dim(cur_target, 1024);
        m = (w > h) ? w : h;
        nw = (w * t) / m;
        nh = (h * t) / m;
        padl = (t - nw) / 2;
        padt = (t - nh) / 2;
    endfunction

    function automatic result_t scale_pixel(input logic [9:0] ox, input logic [9:0] oy);
        result_t r;
        longint unsigned w, h, t, nw, nh, padl, padt, m;
        longint unsigned x0, x1, fx, y0, y1, fy, w00, w01, w10, w11, v, one;
        logic [23:0] p00, p01, p10, p11;
        letterbox_geometry(w, h, t, nw, nh, padl, padt);
        m = (w > h) ? w : h;
        one = 64'd1 << FRAC_BITS;
        r.res_b = PAD_GRAY;
        r.res_g = PAD_GRAY;
        r.res_r = PAD_GRAY;
        r.in_content = 1'b0;
        r.pad_left = padl[PAD_W-1:0];
        r.pad_top = padt[PAD_W-1:0];
        r.scale_fixed = SCL_W'((t << 16) / m);
        if (ox < t && oy < t && ox >= padl && ox < padl + nw &&
            oy >= padt && oy < padt + nh) begin
            map_coord(ox - padl, w, nw, x0, x1, fx);
            map_coord(oy - padt, h, nh, y0, y1, fy);
            w00 = (one - fx) * (one - fy);
            w01 = fx * (one - fy);
            w10 = (one - fx) * fy;
            w11 = fx * fy;
            p00 = pixel_mem[{y0[7:0], x0[7:0]}];
            p01 = pixel_mem[{y0[7:0], x1[7:0]}];
            p10 = pixel_mem[{y1[7:0], x0[7:0]}];
            p11 = pixel_mem[{y1[7:0], x1[7:0]}];
            for (int c = 0; c < 3; c++) begin
                v = w00 * p00[8*c +: 8] + w01 * p01[8*c +: 8]
                  + w10 * p10[8*c +: 8] + w11 * p11[8*c +: 8];
                v = v >> (2 * FRAC_BITS);
                if (v > 255) v = 255;
                if (c == 0) r.res_b = v[7:0];
                else if (c == 1) r.res_g = v[7:0];
                else r.res_r = v[7:0];
            end
            r.in_content = 1'b1;
        end
        return r;
    endfunction

    function automatic logic all_known(input logic [9:0] ox, input logic [9:0] oy);
        longint unsigned w, h, t, nw, nh, padl, padt, x0, x1, fx, y0, y1, fy;
        letterbox_geometry(w, h, t, nw, nh, padl, padt);
        map_coord(ox - padl, w, nw, x0, x1, fx);
        map_coord(oy - padt, h, nh, y0, y1, fy);
        return pixel_known[{y0[7:0], x0[7:0]}] && pixel_known[{y0[7:0], x1[7:0]}] &&
               pixel_known[{y1[7:0], x0[7:0]}] && pixel_known[{y1[7:0], x1[7:0]}];
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DW'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SRC_WIDTH) cur_width = DIM_W'(val);
        else if (idx == CFG_SRC_HEIGHT) cur_height = DIM_W'(val);
        else if (idx == CFG_TARGET) cur_target = TGT_W'(val);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned t);
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_TARGET, t);
    endtask

    // drive one transfer; valid stays high into the next item unless a random pause drops it
    task automatic send_item(input logic op, input logic [7:0] lx, ly, pb, pg, pr,
                             input logic [9:0] ox, oy);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, oy, ox, pr, pg, pb, ly, lx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_LOAD) begin
            pixel_mem[{ly, lx}] = {pr, pg, pb};
            pixel_known[{ly, lx}] = 1'b1;
            load_count++;
        end else begin
            pending_pixels.push_back(scale_pixel(ox, oy));
            query_count++;
        end
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_load(input logic [7:0] lx, ly);
        send_item(OP_LOAD, lx, ly, 8'($urandom), 8'($urandom), 8'($urandom), '0, '0);
    endtask

    // load the whole w x h image so every query reads written entries
    task automatic load_image(input int unsigned w, input int unsigned h, input int mode);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (mode == 0)
                    send_load(8'(x), 8'(y));
                else
                    send_item(OP_LOAD, 8'(x), 8'(y), {8{mode[0]}}, {8{mode[0]}},
                              {8{mode[0]}}, '0, '0);
    endtask

    task automatic send_query(input logic [9:0] ox, oy);
        send_item(OP_QUERY, '0, '0, 8'($urandom), 8'($urandom), 8'($urandom), ox, oy);
    endtask

    task automatic drain_and_pause;
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            idle_cycles <= 0;
            got.res_b = m_tdata[7:0];
            got.res_g = m_tdata[15:8];
            got.res_r = m_tdata[23:16];
            got.pad_left = m_tdata[32:24];
            got.pad_top = m_tdata[41:33];
            got.scale_fixed = m_tdata[68:42];
            got.in_content = m_tuser;
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output pixel %h user %b", m_tdata, m_tuser);
            end else begin
                want = pending_pixels.pop_front();
                if (want.in_content) content_count++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("pixel mismatch: exp b%0d g%0d r%0d c%0b pl%0d pt%0d s%0h",
                                 want.res_b, want.res_g, want.res_r, want.in_content,
                                 want.pad_left, want.pad_top, want.scale_fixed);
                        $display("                got b%0d g%0d r%0d c%0b pl%0d pt%0d s%0h",
                                 got.res_b, got.res_g, got.res_r, got.in_content,
                                 got.pad_left, got.pad_top, got.scale_fixed);
                    end
                end
            end
        end else if (aresetn && s_tvalid && s_tready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern: alternate stretches of steady ready and random stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 40) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    stim_row_t directed_rows[$];

    initial begin
        stim_row_t row;
        int unsigned w, h, t;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        stall_mode = 1'b0;
        idle_cycles = 0;
        mismatch_count = 0;
        query_count = 0;
        load_count = 0;
        content_count = 0;
        cur_width = 9'd256;
        cur_height = 9'd256;
        cur_target = 11'd640;
        for (int i = 0; i < 65536; i++) begin
            pixel_mem[i] = '0;
            pixel_known[i] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry 256x256 -> 640: padding queries only (no store reads)
        directed_rows = '{
            '{OP_QUERY, 0, 0, 0, 0, 0, 10'd640, 10'd0, 1, PAD_GRAY, 0},
            '{OP_QUERY, 0, 0, 0, 0, 0, 10'd1023, 10'd1023, 1, PAD_GRAY, 0},
            '{OP_QUERY, 0, 0, 0, 0, 0, 10'd0, 10'd640, 1, PAD_GRAY, 0},
            // load outside nothing: all addresses are in range; extreme corners
            '{OP_LOAD, 8'd255, 8'd255, 8'hff, 8'h00, 8'hff, 0, 0, 0, 0, 0},
            '{OP_LOAD, 8'd0, 8'd255, 8'h00, 8'hff, 8'h00, 0, 0, 0, 0, 0}
        };
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.op, row.lx, row.ly, row.pb, row.pg, row.pr, row.ox, row.oy);
            if (row.fixed_res && pending_pixels.size() != 0) begin
                if (pending_pixels[$].res_b != row.fixed_gray ||
                    pending_pixels[$].in_content != row.fixed_content) begin
                    mismatch_count++;
                    $display("directed row %0d disagrees with predictor", i);
                end
            end
        end
        drain_and_pause();

        // 1x1 source, constant and extreme images, tiny and out-of-range targets
        set_geometry(1, 1, 1);
        send_item(OP_LOAD, 0, 0, 8'hff, 8'hff, 8'hff, '0, '0);
        send_query(0, 0);
        send_query(1, 0);
        drain_and_pause();
        set_geometry(0, 0, 0);          // saturates to 1,1,1
        send_query(0, 0);
        send_item(OP_LOAD, 0, 0, 8'h00, 8'h00, 8'h00, '0, '0);
        send_query(0, 0);
        drain_and_pause();
        set_geometry(3, 2, 2047);       // target saturates to 1024
        load_image(3, 2, 1);
        send_query(10'd1023, 10'd512);
        send_query(10'd0, 10'd0);
        send_query(10'd512, 10'd512);
        drain_and_pause();
        set_geometry(511, 1, 3);        // width saturates; empty scaled height
        send_query(0, 1);
        send_query(2, 1);
        drain_and_pause();

        // random phases over a range of geometries
        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 0) begin w = 256; h = 256; t = 1024; end
            else if (ph == 1) begin w = 2; h = 256; t = 1; end
            else if (ph == 2) begin w = 256; h = 1; t = 1024; end
            else begin
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 12);
                h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 12);
                t = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 200);
            end
            set_geometry(w, h, t);
            if (w * h <= 64) load_image(w, h, 0);
            else begin
                // large images: only the top-left corner, up to 4 x 4, loaded
                load_image(w < 4 ? w : 4, h < 4 ? h : 4, 0);
            end
            for (int n = 0; n < 64; n++) begin
                logic [9:0] ox, oy;
                int unsigned tc;
                logic do_load;
                result_t probe;
                tc = clamp_dim(cur_target, 1024);
                case ($urandom_range(0, 3))
                    0: begin ox = 10'($urandom); oy = 10'($urandom); end
                    default: begin
                        ox = 10'($urandom_range(0, tc - 1));
                        oy = 10'($urandom_range(0, tc - 1));
                    end
                endcase
                do_load = ($urandom_range(0, 5) == 0);
                probe = scale_pixel(ox, oy);
                // avoid reading unwritten entries: send a load instead
                if (w * h > 64 && probe.in_content && !all_known(ox, oy)) do_load = 1'b1;
                if (do_load)
                    send_load(8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)));
                else
                    send_query(ox, oy);
            end
            drain_and_pause();
        end

        $display("covered %0d loads and %0d queries, %0d inside the scaled image",
                 load_count, query_count, content_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
